>>> rtl/fasta_scaffold_stats_top_defines.svh
// ---------------------------------------------------------------------------
// fasta_scaffold_stats_top_defines: assertion macros
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef FASTA_SCAFFOLD_STATS_TOP_DEFINES_SVH
`define FASTA_SCAFFOLD_STATS_TOP_DEFINES_SVH

`ifndef SYNTH
`define FSS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define FSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FSS_ASSERT(lbl, cond)
`define FSS_ASSERT_IMP(lbl, ante, cons)
`define FSS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/fss_pkg.sv
// ---------------------------------------------------------------------------
// fss_pkg: shared types and constants
// Beat payloads, statistics bundle and character codes.
// ---------------------------------------------------------------------------
package fss_pkg;

  localparam int OUT_LEN_W = 40;
  localparam int COUNT_W   = 32;

  localparam logic [7:0] CHAR_GT = 8'h3E;
  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_A  = 8'h41;
  localparam logic [7:0] CHAR_C  = 8'h43;
  localparam logic [7:0] CHAR_G  = 8'h47;
  localparam logic [7:0] CHAR_T  = 8'h54;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       is_final;
  } fss_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   scaffold_count;
    logic [OUT_LEN_W-1:0] longest_length;
    logic [OUT_LEN_W-1:0] total_length;
    logic [OUT_LEN_W-1:0] count_a;
    logic [OUT_LEN_W-1:0] count_c;
    logic [OUT_LEN_W-1:0] count_g;
    logic [OUT_LEN_W-1:0] count_t;
  } fss_stats_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   scaffold_count;
    logic [OUT_LEN_W-1:0] longest_length;
    logic [OUT_LEN_W-1:0] total_length;
    logic [OUT_LEN_W-1:0] count_a;
    logic [OUT_LEN_W-1:0] count_c;
    logic [OUT_LEN_W-1:0] count_g;
    logic [OUT_LEN_W-1:0] count_t;
    logic [7:0]           name_char;
    logic [3:0]           name_pos;
    logic                 run_end;
  } fss_out_t;

endpackage

>>> rtl/fss_ingest.sv
// ---------------------------------------------------------------------------
// fss_ingest: input register and per-byte statistics update
// Parses headers and sequence, keeps the running counts, loads a snapshot.
// ---------------------------------------------------------------------------
`include "fasta_scaffold_stats_top_defines.svh"

module fss_ingest #(
  parameter int NAME_CHARS = 14,
  parameter int LEN_BITS   = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fss_pkg::fss_in_t            in_data,
  input  logic                        snap_free,
  output logic                        snap_load,
  output fss_pkg::fss_stats_t         snap_stats,
  output logic [NAME_CHARS-1:0][7:0]  snap_name
);
  import fss_pkg::*;

  localparam int FW = $clog2(NAME_CHARS + 1);

  logic                        vld_r;
  logic [7:0]                  byte_r;
  logic                        final_r;
  logic                        consume;

  logic                        in_hdr_r, in_hdr_nxt;
  logic [LEN_BITS-1:0]         cur_r, cur_nxt;
  logic [NAME_CHARS-1:0][7:0]  hc_r, hc_nxt;
  logic [FW-1:0]               fill_r, fill_nxt;
  logic [NAME_CHARS-1:0][7:0]  bn_r, bn_nxt;
  logic [LEN_BITS-1:0]         best_r, best_nxt;
  logic [LEN_BITS-1:0]         total_r, total_nxt;
  logic [COUNT_W-1:0]          cnt_r, cnt_nxt;
  logic [3:0][LEN_BITS-1:0]    base_r, base_nxt;

  logic                        is_gt, is_nl, close_gt, close_win, hdr_a, win_fin;
  logic [LEN_BITS-1:0]         fin_len;
  logic [NAME_CHARS-1:0][7:0]  fin_name;

  function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [OUT_LEN_W-1:0] to_out(input logic [LEN_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[OUT_LEN_W-1:0];
  endfunction

  assign consume  = vld_r && (!final_r || snap_free);
  assign in_ready = !vld_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_r  <= in_data.byte_in;
      final_r <= in_data.is_final;
    end
  end

  always_comb begin
    is_gt     = (byte_r == CHAR_GT);
    is_nl     = (byte_r == CHAR_NL);
    close_gt  = is_gt && (cur_r != '0);
    close_win = close_gt && (cur_r > best_r);
    hdr_a     = in_hdr_r || is_gt;

    best_nxt   = close_win ? cur_r : best_r;
    bn_nxt     = close_win ? hc_r : bn_r;
    cur_nxt    = close_gt ? '0 : cur_r;
    in_hdr_nxt = hdr_a;
    hc_nxt     = hc_r;
    fill_nxt   = fill_r;
    total_nxt  = total_r;
    cnt_nxt    = cnt_r;
    base_nxt   = base_r;

    if (hdr_a) begin
      if (is_nl) begin
        in_hdr_nxt = 1'b0;
        cnt_nxt    = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
        for (int i = 0; i < NAME_CHARS; i++) begin
          if (FW'(i) >= fill_r) hc_nxt[i] = '0;
        end
        fill_nxt = '0;
      end else if (!is_gt && fill_r < FW'(NAME_CHARS)) begin
        for (int i = 0; i < NAME_CHARS; i++) begin
          if (FW'(i) == fill_r) hc_nxt[i] = byte_r;
        end
        fill_nxt = fill_r + 1'b1;
      end
    end else if (!is_nl) begin
      cur_nxt   = sat_inc(cur_nxt);
      total_nxt = sat_inc(total_r);
      case (byte_r)
        CHAR_A:  base_nxt[0] = sat_inc(base_r[0]);
        CHAR_C:  base_nxt[1] = sat_inc(base_r[1]);
        CHAR_G:  base_nxt[2] = sat_inc(base_r[2]);
        CHAR_T:  base_nxt[3] = sat_inc(base_r[3]);
        default: ;
      endcase
    end

    win_fin  = (cur_nxt > best_nxt);
    fin_len  = win_fin ? cur_nxt : best_nxt;
    fin_name = win_fin ? hc_nxt : bn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (consume && final_r)) begin
      in_hdr_r <= 1'b0;
      cur_r    <= '0;
      hc_r     <= '0;
      fill_r   <= '0;
      bn_r     <= '0;
      best_r   <= '0;
      total_r  <= '0;
      cnt_r    <= '0;
      base_r   <= '0;
    end else if (consume) begin
      in_hdr_r <= in_hdr_nxt;
      cur_r    <= cur_nxt;
      hc_r     <= hc_nxt;
      fill_r   <= fill_nxt;
      bn_r     <= bn_nxt;
      best_r   <= best_nxt;
      total_r  <= total_nxt;
      cnt_r    <= cnt_nxt;
      base_r   <= base_nxt;
    end
  end

  assign snap_load                 = vld_r && final_r && snap_free;
  assign snap_name                 = fin_name;
  assign snap_stats.scaffold_count = cnt_nxt;
  assign snap_stats.longest_length = to_out(fin_len);
  assign snap_stats.total_length   = to_out(total_nxt);
  assign snap_stats.count_a        = to_out(base_nxt[0]);
  assign snap_stats.count_c        = to_out(base_nxt[1]);
  assign snap_stats.count_g        = to_out(base_nxt[2]);
  assign snap_stats.count_t        = to_out(base_nxt[3]);

  `FSS_ASSERT(a_fill_max, fill_r <= FW'(NAME_CHARS))
  `FSS_ASSERT_NXT(a_final_clears, consume && final_r,
                  cur_r == '0 && !in_hdr_r && fill_r == '0 && best_r == '0)
  `FSS_ASSERT_IMP(a_best_bounds_total, 1'b1, best_r <= total_r)

endmodule

>>> rtl/fss_emit.sv
// ---------------------------------------------------------------------------
// fss_emit: result snapshot and beat sequencer
// Holds one run of statistics and sends one result beat per name character.
// ---------------------------------------------------------------------------
`include "fasta_scaffold_stats_top_defines.svh"

module fss_emit #(
  parameter int NAME_CHARS = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        snap_load,
  input  fss_pkg::fss_stats_t         snap_stats,
  input  logic [NAME_CHARS-1:0][7:0]  snap_name,
  output logic                        snap_free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fss_pkg::fss_out_t           out_data
);
  import fss_pkg::*;

  localparam int PW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;

  logic                        busy_r;
  logic [PW-1:0]               pos_r;
  fss_stats_t                  stats_r;
  logic [NAME_CHARS-1:0][7:0]  name_r, name_nxt;
  logic                        last;

  assign last      = (pos_r == PW'(NAME_CHARS - 1));
  assign snap_free = !busy_r || (out_ready && last);

  always_comb begin
    for (int i = 0; i < NAME_CHARS - 1; i++) begin
      name_nxt[i] = name_r[i+1];
    end
    name_nxt[NAME_CHARS-1] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else if (snap_load) begin
      busy_r <= 1'b1;
      pos_r  <= '0;
    end else if (busy_r && out_ready) begin
      if (last) begin
        busy_r <= 1'b0;
        pos_r  <= '0;
      end else begin
        pos_r <= pos_r + 1'b1;
      end
    end
    if (snap_load) begin
      stats_r <= snap_stats;
      name_r  <= snap_name;
    end else if (busy_r && out_ready) begin
      name_r <= name_nxt;
    end
  end

  assign out_valid               = busy_r;
  assign out_data.scaffold_count = stats_r.scaffold_count;
  assign out_data.longest_length = stats_r.longest_length;
  assign out_data.total_length   = stats_r.total_length;
  assign out_data.count_a        = stats_r.count_a;
  assign out_data.count_c        = stats_r.count_c;
  assign out_data.count_g        = stats_r.count_g;
  assign out_data.count_t        = stats_r.count_t;
  assign out_data.name_char      = name_r[0];
  assign out_data.name_pos       = 4'(pos_r);
  assign out_data.run_end        = last;

  `FSS_ASSERT_IMP(a_pos_range, busy_r, pos_r <= PW'(NAME_CHARS - 1))
  `FSS_ASSERT_NXT(a_load_start, snap_load, busy_r && pos_r == '0)
  `FSS_ASSERT_NXT(a_run_done, busy_r && out_ready && last && !snap_load, !busy_r)

endmodule

>>> rtl/fasta_scaffold_stats_top.sv
// ---------------------------------------------------------------------------
// fasta_scaffold_stats_top: FASTA scaffold statistics
// Input channel: one file byte per beat, is_final set on the last byte.
// Output channel: NAME_CHARS result beats per file, one per character of the
// longest scaffold name, each carrying all counts; run_end marks the last.
// Throughput: one byte per cycle unless a final byte waits for the snapshot;
// the per-byte update is a single pass of compares and saturating increments
// behind the input register. A final byte loads the snapshot from the input
// register when the snapshot is free, then the first result beat is valid;
// the beats of a run follow back to back while out_ready is high. The next
// file's bytes are taken while a run drains. A final byte waits in the input
// register until the previous run's last beat is taken, so very short files may stall.
// Stall: out_data holds while out_valid is high and out_ready is low.
// Reset: rst_n low clears all counters, the name store and both channels.
// After each final byte the counters return to zero for the next file.
// ---------------------------------------------------------------------------
module fasta_scaffold_stats_top #(
  parameter int NAME_CHARS = 14,
  parameter int LEN_BITS   = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fss_pkg::fss_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fss_pkg::fss_out_t  out_data
);
  import fss_pkg::*;

  logic                        snap_load;
  logic                        snap_free;
  fss_stats_t                  snap_stats;
  logic [NAME_CHARS-1:0][7:0]  snap_name;

  fss_ingest #(
    .NAME_CHARS (NAME_CHARS),
    .LEN_BITS   (LEN_BITS)
  ) u_ingest (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .snap_free  (snap_free),
    .snap_load  (snap_load),
    .snap_stats (snap_stats),
    .snap_name  (snap_name)
  );

  fss_emit #(
    .NAME_CHARS (NAME_CHARS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_load  (snap_load),
    .snap_stats (snap_stats),
    .snap_name  (snap_name),
    .snap_free  (snap_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

>>> sim/fss_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fss_checker: result checker for fasta_scaffold_stats_top
// Watches the byte and result channels and keeps its own running copy of the
// FASTA statistics. It queues the name beats that each final byte should
// produce and compares every result beat, field by field, with the oldest
// one in the queue.
// ---------------------------------------------------------------------------
module fss_checker #(
  parameter int NAME_CHARS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  fss_pkg::fss_in_t   in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  fss_pkg::fss_out_t  out_data,
  output int unsigned        fail_count,
  output int unsigned        beats_waiting,
  output int unsigned        beats_checked,
  output int unsigned        files_seen
);

  localparam int SHOW_MAX = 100;

  typedef logic [fss_pkg::OUT_LEN_W-1:0] len_t;
  typedef enum int {BASE_A, BASE_C, BASE_G, BASE_T} base_e;

  logic                        hdr_open;
  len_t                        cur_len;
  len_t                        best_len;
  len_t                        seq_total;
  len_t                        base_cnt [4];
  logic [7:0]                  hdr_name [NAME_CHARS];
  logic [7:0]                  best_name [NAME_CHARS];
  int unsigned                 hdr_fill;
  logic [fss_pkg::COUNT_W-1:0] scaffolds;

  fss_pkg::fss_out_t name_beats_q[$];
  int unsigned n_fail    = 0;
  int unsigned n_checked = 0;
  int unsigned n_files   = 0;

  function automatic len_t sat_inc(len_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic clear_file();
    hdr_open  = 1'b0;
    cur_len   = '0;
    best_len  = '0;
    seq_total = '0;
    hdr_fill  = 0;
    scaffolds = '0;
    for (int i = 0; i < 4; i++) base_cnt[i] = '0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      hdr_name[i]  = '0;
      best_name[i] = '0;
    end
  endtask

  task automatic close_scaffold();
    if (cur_len > best_len) begin
      best_len  = cur_len;
      best_name = hdr_name;
    end
    cur_len = '0;
  endtask

  task automatic scan_byte(fss_pkg::fss_in_t beat);
    fss_pkg::fss_out_t res;
    logic [7:0]        b;
    b = beat.byte_in;
    if (b == fss_pkg::CHAR_GT) begin
      hdr_open = 1'b1;
      if (cur_len != '0) close_scaffold();
    end
    if (hdr_open) begin
      if (b == fss_pkg::CHAR_NL) begin
        hdr_open = 1'b0;
        if (scaffolds != '1) scaffolds = scaffolds + 1'b1;
        for (int i = 0; i < NAME_CHARS; i++) begin
          if (i >= hdr_fill) hdr_name[i] = '0;
        end
        hdr_fill = 0;
      end else if (b != fss_pkg::CHAR_GT && hdr_fill < NAME_CHARS) begin
        hdr_name[hdr_fill] = b;
        hdr_fill++;
      end
    end else if (b != fss_pkg::CHAR_NL) begin
      cur_len   = sat_inc(cur_len);
      seq_total = sat_inc(seq_total);
      case (b)
        fss_pkg::CHAR_A: base_cnt[BASE_A] = sat_inc(base_cnt[BASE_A]);
        fss_pkg::CHAR_C: base_cnt[BASE_C] = sat_inc(base_cnt[BASE_C]);
        fss_pkg::CHAR_G: base_cnt[BASE_G] = sat_inc(base_cnt[BASE_G]);
        fss_pkg::CHAR_T: base_cnt[BASE_T] = sat_inc(base_cnt[BASE_T]);
        default: ;
      endcase
    end
    if (beat.is_final) begin
      close_scaffold();
      for (int k = 0; k < NAME_CHARS; k++) begin
        res.scaffold_count = scaffolds;
        res.longest_length = best_len;
        res.total_length   = seq_total;
        res.count_a        = base_cnt[BASE_A];
        res.count_c        = base_cnt[BASE_C];
        res.count_g        = base_cnt[BASE_G];
        res.count_t        = base_cnt[BASE_T];
        res.name_char      = best_name[k];
        res.name_pos       = 4'(k);
        res.run_end        = (k == NAME_CHARS - 1);
        name_beats_q.push_back(res);
      end
      n_files++;
      clear_file();
    end
  endtask

  task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    n_fail++;
    if (n_fail <= SHOW_MAX)
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    else if (n_fail == SHOW_MAX + 1)
      $display("%0t: further mismatches not shown", $time);
  endtask

  task automatic check_beat(fss_pkg::fss_out_t got);
    fss_pkg::fss_out_t want;
    if (name_beats_q.size() == 0) begin
      note_mismatch("unexpected beat", '0, 64'(got.name_char));
      return;
    end
    want = name_beats_q.pop_front();
    n_checked++;
    if (got.scaffold_count !== want.scaffold_count)
      note_mismatch("scaffold_count", 64'(want.scaffold_count), 64'(got.scaffold_count));
    if (got.longest_length !== want.longest_length)
      note_mismatch("longest_length", 64'(want.longest_length), 64'(got.longest_length));
    if (got.total_length !== want.total_length)
      note_mismatch("total_length", 64'(want.total_length), 64'(got.total_length));
    if (got.count_a !== want.count_a)
      note_mismatch("count_a", 64'(want.count_a), 64'(got.count_a));
    if (got.count_c !== want.count_c)
      note_mismatch("count_c", 64'(want.count_c), 64'(got.count_c));
    if (got.count_g !== want.count_g)
      note_mismatch("count_g", 64'(want.count_g), 64'(got.count_g));
    if (got.count_t !== want.count_t)
      note_mismatch("count_t", 64'(want.count_t), 64'(got.count_t));
    if (got.name_char !== want.name_char)
      note_mismatch("name_char", 64'(want.name_char), 64'(got.name_char));
    if (got.name_pos !== want.name_pos)
      note_mismatch("name_pos", 64'(want.name_pos), 64'(got.name_pos));
    if (got.run_end !== want.run_end)
      note_mismatch("run_end", 64'(want.run_end), 64'(got.run_end));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_file();
      name_beats_q.delete();
    end else begin
      if (in_valid && in_ready) scan_byte(in_data);
      if (out_valid && out_ready) check_beat(out_data);
    end
    fail_count    <= n_fail;
    beats_waiting <= name_beats_q.size();
    beats_checked <= n_checked;
    files_seen    <= n_files;
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench for fasta_scaffold_stats_top
// Streams FASTA files into the block one byte per beat: a few hand-built
// files for the corner cases, then random files, mostly well formed with
// some noise and truncated ones. Both channels idle at random in changing
// mixes, with one long output hold; fss_checker predicts and compares.
// ---------------------------------------------------------------------------
module tb;

  localparam int NAME_CHARS   = 14;
  localparam int ITEMS_TARGET = 450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {PH_SLOW_SEND, PH_SLOW_RECV, PH_FULL_RATE} phase_e;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  fss_pkg::fss_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  fss_pkg::fss_out_t out_data;

  phase_e      phase      = PH_SLOW_SEND;
  int unsigned bytes_sent = 0;
  int unsigned fail_count;
  int unsigned beats_waiting;
  int unsigned beats_checked;
  int unsigned files_seen;
  logic [7:0]  file_q[$];

  fasta_scaffold_stats_top #(
    .NAME_CHARS (NAME_CHARS),
    .LEN_BITS   (fss_pkg::OUT_LEN_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  fss_checker #(
    .NAME_CHARS (NAME_CHARS)
  ) u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .beats_waiting (beats_waiting),
    .beats_checked (beats_checked),
    .files_seen    (files_seen)
  );

  initial begin : clk_gen
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] seq_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    case ($urandom_range(3))
      0: seq_byte = fss_pkg::CHAR_A;
      1: seq_byte = fss_pkg::CHAR_C;
      2: seq_byte = fss_pkg::CHAR_G;
      default: seq_byte = fss_pkg::CHAR_T;
    endcase
    if (roll < 8) seq_byte = "N";
    else if (roll < 14) seq_byte = seq_byte | 8'h20;
    else if (roll < 17) seq_byte = 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] name_byte();
    if ($urandom_range(19) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(9))
      0: return fss_pkg::CHAR_GT;
      1: return fss_pkg::CHAR_NL;
      2: return seq_byte();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endtask

  task automatic add_seq_line();
    repeat ($urandom_range(0, 12)) file_q.push_back(seq_byte());
    file_q.push_back(fss_pkg::CHAR_NL);
  endtask

  task automatic build_random_file();
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 16)) file_q.push_back(noise_byte());
    end else if (kind < 18) begin
      repeat ($urandom_range(1, 2)) file_q.push_back(seq_byte());
    end else begin
      if ($urandom_range(4) == 0) add_seq_line();
      repeat ($urandom_range(1, 3)) begin
        file_q.push_back(fss_pkg::CHAR_GT);
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(15, 20)) file_q.push_back(name_byte());
        else
          repeat ($urandom_range(0, 10)) file_q.push_back(name_byte());
        file_q.push_back(fss_pkg::CHAR_NL);
        repeat ($urandom_range(0, 2)) add_seq_line();
      end
      case ($urandom_range(7))
        0: begin
          file_q.push_back(fss_pkg::CHAR_GT);
          repeat ($urandom_range(0, 4)) file_q.push_back(name_byte());
        end
        1: repeat ($urandom_range(1, 4)) file_q.push_back(noise_byte());
        2: repeat ($urandom_range(1, 5)) file_q.push_back(seq_byte());
        default: ;
      endcase
    end
  endtask

  task automatic send_byte(logic [7:0] b, logic fin);
    fss_pkg::fss_in_t beat;
    int unsigned      gap_pct;
    gap_pct = (phase == PH_SLOW_SEND) ? 34 : (phase == PH_SLOW_RECV) ? 84 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    beat.byte_in  = b;
    beat.is_final = fin;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_ready !== 1'b1);
    bytes_sent++;
    phase <= (bytes_sent < 160) ? PH_SLOW_SEND :
             (bytes_sent < 320) ? PH_SLOW_RECV : PH_FULL_RATE;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  initial begin : out_drive
    int unsigned hold_left;
    int unsigned stall_pct;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == PH_FULL_RATE && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        stall_pct = (phase == PH_SLOW_SEND) ? 84 : (phase == PH_SLOW_RECV) ? 34 : 0;
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles", cycles);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_text("GT");
    file_q.push_back(8'h00);
    file_q.push_back(8'hFF);
    add_text("\n>n>m\nACGTC");
    send_file();
    add_text(">q");
    send_file();
    add_text("T");
    send_file();
    add_text(">a\nC>b\nG");
    send_file();

    while (bytes_sent < ITEMS_TARGET) begin
      build_random_file();
      send_file();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (beats_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d bytes in %0d files; %0d result beats compared.",
             bytes_sent, files_seen, beats_checked);
    $display("Idle mixes: slow sender, slow receiver, full rate; one %0d-cycle output hold.",
             HOLD_CYCLES);
    if (fail_count == 0 && beats_waiting == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
